### src/hrs_pkg.sv
// hrs_pkg: sizes, generator constants and the controller/datapath command types
// of the hashed random shuffle block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hrs_pkg;

    // batch store
    localparam int MAX_ITEMS  = 64;
    localparam int ITEM_WIDTH = 8;
    localparam int IDX_W      = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
    localparam int REM_W      = $clog2(2 * MAX_ITEMS);

    // generator
    localparam int GEN_W       = 64;
    localparam int HALF_W      = GEN_W / 2;
    localparam int MUL_A_W     = 15;
    localparam int PROD_W      = HALF_W + MUL_A_W;
    localparam int DIV_CNT_W   = $clog2(GEN_W);
    localparam int GEN_ROT     = 17;
    localparam int MUL_B_SHIFT = 16;   // 65537 = 1 + 2^16

    localparam logic [GEN_W-1:0]   GEN_SEED  = 64'hCAFE_BABE_DEAD_BEEF;
    localparam logic [MUL_A_W-1:0] GEN_MUL_A = 15'd31337;
    localparam logic [GEN_W-1:0]   GEN_XOR_A = 64'h0000_0000_FEED_FACE;
    localparam logic [GEN_W-1:0]   GEN_SUB   = 64'd911911911911;
    localparam logic [GEN_W-1:0]   GEN_XOR_B = 64'h0003_1415_9265_3589;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_SWAP_I,
        WR_SWAP_J
    } hrs_wr_sel_t;

    typedef struct packed {
        logic        load_take;  // input request accepted this cycle
        logic        mul_lo;     // low half times 31337
        logic        mul_hi;     // high half times 31337, combine
        logic        mix_a;      // xor, rotate, subtract
        logic        mix_b;      // times 65537, xor, start modulo
        logic        div_step;   // one remainder bit
        logic        rd_j;       // read store at target instead of index
        logic        latch_vi;   // hold item at index
        hrs_wr_sel_t wr_sel;
        logic        idx_clr;
        logic        idx_inc;
        logic        out_load;
        logic        count_clr;
    } hrs_cmd_t;

    typedef struct packed {
        logic last_pos;   // index is the final position of the batch
        logic swap_need;  // target differs from index
        logic out_free;   // output register can take a new request
    } hrs_status_t;

endpackage

`default_nettype wire

### src/hrs_if.sv
// hrs_if: valid/ready channel interfaces for input items and shuffled results.
// Depends on hrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface hrs_in_if;
    logic                           valid;
    logic                           ready;
    logic [hrs_pkg::ITEM_WIDTH-1:0] item_value;
    logic                           item_last;

    modport source (output valid, output item_value, output item_last, input ready);
    modport sink (input valid, input item_value, input item_last, output ready);
endinterface

interface hrs_out_if;
    logic                           valid;
    logic                           ready;
    logic [hrs_pkg::ITEM_WIDTH-1:0] out_value;
    logic                           out_last;

    modport source (output valid, output out_value, output out_last, input ready);
    modport sink (input valid, input out_value, input out_last, output ready);
endinterface

`default_nettype wire

### src/hashed_random_shuffle.sv
// hashed_random_shuffle: top level, joins sequencer, datapath and channels.
// Depends on hrs_pkg, hrs_if, hrs_ram, hrs_datapath and hrs_ctrl.
`timescale 1ns / 1ps
`default_nettype none

// The block collects a batch of 8-bit items, one per input request, until a
// request marked last arrives; items past the 64-entry store are dropped, but
// a dropped last item still closes the batch. The batch is then shuffled in
// place: for every position a 64-bit generator (seeded once at reset and never
// reseeded between batches) is advanced, its value modulo the batch size picks
// a partner, and the two entries are swapped. The shuffled batch leaves in
// order, one output request per item, with the final one marked last.
// Loading takes one item per cycle while requests are offered. Each shuffle
// position advances the generator, runs the one-bit-per-cycle modulo unit and
// reads the item at the index; a swap adds a read at the partner and two
// writes (the store has a single read and a single write port). Emission loads
// each item when the output register is free. The input takes no item from
// the last request of a batch until its final result sits in the output
// register; that result may wait there while the next batch loads.

module hashed_random_shuffle (
    input wire logic clk,
    input wire logic rst_n,
    hrs_in_if.sink   in_ch,
    hrs_out_if.source out_ch
);

    hrs_pkg::hrs_cmd_t    cmd;
    hrs_pkg::hrs_status_t status;
    logic                 ready;

    // sequencer: owns the input handshake and all step timing
    hrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_last  (in_ch.item_last),
        .in_ready (ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: store, generator, modulo unit and output register
    hrs_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .item_value (in_ch.item_value),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_value  (out_ch.out_value),
        .out_last   (out_ch.out_last)
    );

    assign in_ch.ready = ready;

endmodule

`default_nettype wire

### src/hrs_ram.sv
// hrs_ram: generic simple dual-port ram, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### src/hrs_datapath.sv
// hrs_datapath: batch store, generator, bit-serial modulo unit, swap path and
// output register of the shuffle block. Depends on hrs_pkg and hrs_ram.
`timescale 1ns / 1ps
`default_nettype none

module hrs_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire hrs_pkg::hrs_cmd_t              cmd,
    output hrs_pkg::hrs_status_t                status,
    input  wire logic [hrs_pkg::ITEM_WIDTH-1:0] item_value,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [hrs_pkg::ITEM_WIDTH-1:0] out_value,
    output logic                                out_last
);

    logic [hrs_pkg::GEN_W-1:0]      g_reg;
    logic [hrs_pkg::GEN_W-1:0]      mix_reg;
    logic [hrs_pkg::PROD_W-1:0]     plo_reg;
    logic [hrs_pkg::GEN_W-1:0]      div_sh_reg;
    logic [hrs_pkg::REM_W-1:0]      rem_reg;
    logic [hrs_pkg::IDX_W-1:0]      idx_reg;
    logic [hrs_pkg::CNT_W-1:0]      count_reg;
    logic [hrs_pkg::ITEM_WIDTH-1:0] vi_reg;
    logic [hrs_pkg::ITEM_WIDTH-1:0] out_value_reg;
    logic                           out_last_reg;
    logic                           out_valid_reg;

    logic [hrs_pkg::HALF_W-1:0]     mul_in;
    logic [hrs_pkg::PROD_W-1:0]     prod;
    logic [hrs_pkg::HALF_W-1:0]     hi_sum;
    logic [hrs_pkg::GEN_W-1:0]      xa;
    logic [hrs_pkg::GEN_W-1:0]      mix_a_next;
    logic [hrs_pkg::GEN_W-1:0]      mix_b_next;
    logic [hrs_pkg::REM_W-1:0]      rem_sh;
    logic [hrs_pkg::REM_W-1:0]      rem_next;
    logic [hrs_pkg::IDX_W-1:0]      j_idx;
    logic                           store_full;

    logic                           ram_we;
    logic [hrs_pkg::IDX_W-1:0]      ram_waddr;
    logic [hrs_pkg::ITEM_WIDTH-1:0] ram_wdata;
    logic [hrs_pkg::IDX_W-1:0]      ram_raddr;
    logic [hrs_pkg::ITEM_WIDTH-1:0] ram_rdata;

    // one shared 32x15 multiplier for both halves of g * 31337
    assign mul_in = cmd.mul_hi ? g_reg[hrs_pkg::GEN_W-1:hrs_pkg::HALF_W]
                               : g_reg[hrs_pkg::HALF_W-1:0];
    assign prod   = hrs_pkg::PROD_W'(mul_in) * hrs_pkg::PROD_W'(hrs_pkg::GEN_MUL_A);
    assign hi_sum = prod[hrs_pkg::HALF_W-1:0]
                  + hrs_pkg::HALF_W'(plo_reg[hrs_pkg::PROD_W-1:hrs_pkg::HALF_W]);

    assign xa         = mix_reg ^ hrs_pkg::GEN_XOR_A;
    assign mix_a_next = {xa[hrs_pkg::GEN_ROT-1:0], xa[hrs_pkg::GEN_W-1:hrs_pkg::GEN_ROT]}
                      - hrs_pkg::GEN_SUB;
    assign mix_b_next = (mix_reg + (mix_reg << hrs_pkg::MUL_B_SHIFT)) ^ hrs_pkg::GEN_XOR_B;

    // restoring remainder, one dividend bit per step
    assign rem_sh   = {rem_reg[hrs_pkg::REM_W-2:0], div_sh_reg[hrs_pkg::GEN_W-1]};
    assign rem_next = (rem_sh >= hrs_pkg::REM_W'(count_reg))
                    ? rem_sh - hrs_pkg::REM_W'(count_reg) : rem_sh;
    assign j_idx    = rem_reg[hrs_pkg::IDX_W-1:0];

    assign store_full = (count_reg == hrs_pkg::CNT_W'(hrs_pkg::MAX_ITEMS));

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = count_reg[hrs_pkg::IDX_W-1:0];
        ram_wdata = item_value;
        unique case (cmd.wr_sel)
            hrs_pkg::WR_SWAP_I:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
            end
            hrs_pkg::WR_SWAP_J:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_idx;
                ram_wdata = vi_reg;
            end
            default:
            begin
                ram_we = cmd.load_take && !store_full;
            end
        endcase
    end

    assign ram_raddr = cmd.rd_j ? j_idx : idx_reg;

    hrs_ram #(
        .WIDTH (hrs_pkg::ITEM_WIDTH),
        .DEPTH (hrs_pkg::MAX_ITEMS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_reg         <= hrs_pkg::GEN_SEED;
            idx_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.mix_b)
            begin
                g_reg <= mix_b_next;
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.count_clr)
            begin
                count_reg <= '0;
            end
            else if (cmd.load_take && !store_full)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.mul_lo)
        begin
            plo_reg <= prod;
        end
        if (cmd.mul_hi)
        begin
            mix_reg <= {hi_sum, plo_reg[hrs_pkg::HALF_W-1:0]};
        end
        else if (cmd.mix_a)
        begin
            mix_reg <= mix_a_next;
        end
        if (cmd.mix_b)
        begin
            div_sh_reg <= mix_b_next;
            rem_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            div_sh_reg <= div_sh_reg << 1;
            rem_reg    <= rem_next;
        end
        if (cmd.latch_vi)
        begin
            vi_reg <= ram_rdata;
        end
        if (cmd.out_load)
        begin
            out_value_reg <= ram_rdata;
            out_last_reg  <= status.last_pos;
        end
    end

    assign status.last_pos  = (hrs_pkg::CNT_W'(idx_reg) + 1'b1) == count_reg;
    assign status.swap_need = (idx_reg != j_idx);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

### src/hrs_ctrl.sv
// hrs_ctrl: sequencer of the shuffle block: load, per-position generator and
// modulo steps, swap, and emission. Depends on hrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hrs_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_last,
    output logic                      in_ready,
    input  wire hrs_pkg::hrs_status_t status,
    output hrs_pkg::hrs_cmd_t         cmd
);

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MIX_A,
        ST_MIX_B,
        ST_DIV,
        ST_SW_RD_I,
        ST_SW_RD_J,
        ST_SW_WR_I,
        ST_SW_WR_J,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    logic [hrs_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [hrs_pkg::DIV_CNT_W-1:0] div_cnt_next;
    logic                          div_done;

    assign div_done = (div_cnt_reg == hrs_pkg::DIV_CNT_W'(hrs_pkg::GEN_W - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        cmd.wr_sel   = hrs_pkg::WR_NONE;
        in_ready     = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready      = 1'b1;
                cmd.idx_clr   = 1'b1;
                cmd.load_take = in_valid;
                if (in_valid && in_last)
                begin
                    state_next = ST_MUL_LO;
                end
            end
            ST_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = ST_MIX_A;
            end
            ST_MIX_A:
            begin
                cmd.mix_a  = 1'b1;
                state_next = ST_MIX_B;
            end
            ST_MIX_B:
            begin
                cmd.mix_b    = 1'b1;
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_done)
                begin
                    state_next = ST_SW_RD_I;
                end
            end
            ST_SW_RD_I:
            begin
                // read of item at index is issued here either way
                if (status.swap_need)
                begin
                    state_next = ST_SW_RD_J;
                end
                else if (status.last_pos)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_EMIT_RD;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_MUL_LO;
                end
            end
            ST_SW_RD_J:
            begin
                cmd.rd_j     = 1'b1;
                cmd.latch_vi = 1'b1;
                state_next   = ST_SW_WR_I;
            end
            ST_SW_WR_I:
            begin
                cmd.wr_sel = hrs_pkg::WR_SWAP_I;
                state_next = ST_SW_WR_J;
            end
            ST_SW_WR_J:
            begin
                cmd.wr_sel = hrs_pkg::WR_SWAP_J;
                if (status.last_pos)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_EMIT_RD;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_MUL_LO;
                end
            end
            ST_EMIT_RD:
            begin
                if (status.out_free)
                begin
                    state_next = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD:
            begin
                cmd.out_load = 1'b1;
                if (status.last_pos)
                begin
                    cmd.count_clr = 1'b1;
                    cmd.idx_clr   = 1'b1;
                    state_next    = ST_LOAD;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

### sim/tb_hashed_random_shuffle.sv
// tb_hashed_random_shuffle: self-checking bench for the hashed random shuffle block,
// with batch stimulus, a shadow shuffle predictor and random stalls on both channels.
// Depends on hrs_pkg, hrs_if and the hashed_random_shuffle RTL.
`timescale 1ns / 1ps

module tb_hashed_random_shuffle;

    import hrs_pkg::*;

    // bench timing
    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 6;
    // a full 64-item shuffle runs with no request moving, and the long output
    // hold-off adds to that; this is several times over
    localparam int WATCHDOG_LIMIT = 25000;
    localparam int DRAIN_CYCLES   = 200;

    // stimulus sizing
    localparam int TARGET_ITEMS   = 460;

    // long receiver hold-off to back the block up into its input
    localparam int HOLD_AFTER     = 40;
    localparam int HOLD_CYCLES    = 800;

    // which side a wait is drawn for
    localparam int SIDE_SEND      = 0;
    localparam int SIDE_RECV      = 1;

    // generator multiplier that the package only gives as a shift
    localparam logic [GEN_W-1:0] GEN_MUL_B = 64'd65537;

    typedef struct packed {
        logic [ITEM_WIDTH-1:0] value;
        logic                  last;
    } batch_item_t;

    logic clk;
    logic rst_n;

    hrs_in_if  in_bus ();
    hrs_out_if out_bus ();

    hashed_random_shuffle i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_bus),
        .out_ch (out_bus)
    );

    // requests waiting to be offered, and shuffled results waiting to arrive
    batch_item_t pending_items[$];
    batch_item_t shuffled_expect[$];

    // shadow copy of the block state
    logic [ITEM_WIDTH-1:0] shadow_store [MAX_ITEMS];
    int unsigned           shadow_count;
    logic [GEN_W-1:0]      shadow_gen;

    // handshakes seen at the last rising edge
    logic in_took;
    logic out_took;

    // idling state per side: a run of items either stalls at random or not at all
    int run_left [2];
    bit run_busy [2];
    int send_gap;
    int recv_wait;

    int err_cnt;
    int idle_cycles;
    int items_queued;
    int batches_queued;
    int batches_closed;
    int dropped_items;
    int results_checked;
    int max_batch;

    always #(CLK_HALF) clk = ~clk;

    // one step of the batch generator, all wrapping at 64 bits
    function automatic logic [GEN_W-1:0] next_gen(logic [GEN_W-1:0] g);
        g = g * 64'(GEN_MUL_A);
        g = g ^ GEN_XOR_A;
        g = {g[GEN_ROT-1:0], g[GEN_W-1:GEN_ROT]};
        g = g - GEN_SUB;
        g = g * GEN_MUL_B;
        g = g ^ GEN_XOR_B;
        return g;
    endfunction

    // take one accepted request into the shadow store; a last request shuffles
    // the batch and queues its results in output order
    function automatic void absorb_item(logic [ITEM_WIDTH-1:0] value, logic last);
        int unsigned           n;
        int unsigned           j;
        logic [ITEM_WIDTH-1:0] swap_tmp;
        batch_item_t           res;
        if (shadow_count < MAX_ITEMS)
        begin
            shadow_store[shadow_count] = value;
            shadow_count++;
        end
        else
        begin
            dropped_items++;
        end
        if (last)
        begin
            n = shadow_count;
            for (int i = 0; i < n; i++)
            begin
                shadow_gen = next_gen(shadow_gen);
                j = 32'(shadow_gen % 64'(n));
                if (j != i)
                begin
                    swap_tmp        = shadow_store[i];
                    shadow_store[i] = shadow_store[j];
                    shadow_store[j] = swap_tmp;
                end
            end
            for (int k = 0; k < n; k++)
            begin
                res.value = shadow_store[k];
                res.last  = (k == n - 1);
                shuffled_expect.insert(shuffled_expect.size(), res);
            end
            shadow_count = 0;
            batches_closed++;
        end
    endfunction

    // cycles to wait before the next item on one side; runs of items with no
    // idling at all are mixed at random with runs of random stalls
    function automatic int draw_wait(int side);
        if (run_left[side] == 0)
        begin
            run_left[side] = $urandom_range(8, 40);
            run_busy[side] = ($urandom_range(0, 2) != 0);
        end
        run_left[side]--;
        return run_busy[side] ? $urandom_range(0, 15) : 0;
    endfunction

    task automatic add_item(logic [ITEM_WIDTH-1:0] value, logic last);
        batch_item_t it;
        it.value = value;
        it.last  = last;
        pending_items.insert(pending_items.size(), it);
        items_queued++;
    endtask

    // a whole batch of random values; lengths past the store exercise dropping
    task automatic add_batch(int len);
        for (int k = 0; k < len; k++)
        begin
            add_item(ITEM_WIDTH'($urandom_range(0, 255)), k == len - 1);
        end
        batches_queued++;
        if (len > max_batch)
        begin
            max_batch = len;
        end
    endtask

    // sampling at the rising edge: results are checked against the oldest
    // expectation first, then an accepted input request feeds the predictor;
    // a result can never leave in the cycle its batch closes
    always @(posedge clk)
    begin
        batch_item_t want;
        in_took  <= in_bus.valid && in_bus.ready;
        out_took <= out_bus.valid && out_bus.ready;
        if (rst_n)
        begin
            if (out_bus.valid && out_bus.ready)
            begin
                if (shuffled_expect.size() == 0)
                begin
                    $display("%0t: unexpected result: actual value %0h last %0b", $time,
                             out_bus.out_value, out_bus.out_last);
                    err_cnt++;
                end
                else
                begin
                    want = shuffled_expect.pop_front();
                    if (out_bus.out_value !== want.value)
                    begin
                        $display("%0t: out_value mismatch: expected %0h actual %0h", $time,
                                 want.value, out_bus.out_value);
                        err_cnt++;
                    end
                    if (out_bus.out_last !== want.last)
                    begin
                        $display("%0t: out_last mismatch: expected %0b actual %0b", $time,
                                 want.last, out_bus.out_last);
                        err_cnt++;
                    end
                    results_checked++;
                end
            end
            if (in_bus.valid && in_bus.ready)
            begin
                absorb_item(in_bus.item_value, in_bus.item_last);
            end
        end
    end

    // input driver: holds a request until it is taken, then idles for the
    // drawn gap before offering the next one from the queue
    always @(negedge clk)
    begin
        batch_item_t nxt;
        if (rst_n)
        begin
            if (in_bus.valid && !in_took)
            begin
                // request still waiting for ready
            end
            else if (send_gap != 0)
            begin
                in_bus.valid <= 1'b0;
                send_gap--;
            end
            else if (pending_items.size() != 0)
            begin
                nxt = pending_items.pop_front();
                in_bus.valid      <= 1'b1;
                in_bus.item_value <= nxt.value;
                in_bus.item_last  <= nxt.last;
                send_gap = draw_wait(SIDE_SEND);
            end
            else
            begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    // output receiver: after each result it drops ready for the drawn stall;
    // once, after a set number of results, it holds off for a long stretch
    // while the driver keeps offering, so the block backs up and stalls its input
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_took)
            begin
                if (results_checked == HOLD_AFTER)
                begin
                    recv_wait = HOLD_CYCLES;
                end
                else
                begin
                    recv_wait = draw_wait(SIDE_RECV);
                end
            end
            else if (recv_wait != 0)
            begin
                recv_wait--;
            end
            out_bus.ready <= (recv_wait == 0);
        end
    end

    // watchdog: too long with no request moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d results still expected", $time,
                     shuffled_expect.size());
            $display("hashed_random_shuffle test failed");
            $finish;
        end
    end

    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        in_bus.valid      = 1'b0;
        in_bus.item_value = '0;
        in_bus.item_last  = 1'b0;
        out_bus.ready     = 1'b0;
        in_took           = 1'b0;
        out_took          = 1'b0;
        send_gap          = 0;
        recv_wait         = 0;
        run_left          = '{0, 0};
        run_busy          = '{0, 0};
        err_cnt           = 0;
        idle_cycles       = 0;
        items_queued      = 0;
        batches_queued    = 0;
        batches_closed    = 0;
        dropped_items     = 0;
        results_checked   = 0;
        max_batch         = 0;
        shadow_count      = 0;
        shadow_gen        = GEN_SEED;
        foreach (shadow_store[k])
        begin
            shadow_store[k] = '0;
        end

        // directed batches: one-item batches at both value extremes, then short
        // batches with opposite bit patterns so every swap path gets a look
        add_item(8'h00, 1'b1);
        add_item(8'hFF, 1'b1);
        add_item(8'h00, 1'b0);
        add_item(8'hFF, 1'b1);
        add_item(8'hAA, 1'b0);
        add_item(8'h55, 1'b0);
        add_item(8'h0F, 1'b0);
        add_item(8'hF0, 1'b1);
        batches_queued += 4;
        max_batch = 4;
        // one batch of distinct values so a misplaced swap is plain to see
        for (int k = 0; k < 8; k++)
        begin
            add_item(ITEM_WIDTH'(k * 8'h21), k == 7);
        end
        batches_queued++;
        max_batch = 8;
        add_batch(5);

        // random batches, mostly short; a batch that exactly fills the store and
        // one that overruns it (extra items and the last one dropped) are placed
        // among them, plus the odd random long one
        while (items_queued < TARGET_ITEMS)
        begin
            if (batches_queued == 12)
            begin
                add_batch(MAX_ITEMS);
            end
            else if (batches_queued == 25)
            begin
                add_batch(MAX_ITEMS + $urandom_range(1, 6));
            end
            else
            begin
                case ($urandom_range(0, 19))
                    0:        add_batch($urandom_range(MAX_ITEMS, MAX_ITEMS + 6));
                    1, 2, 3:  add_batch($urandom_range(9, 40));
                    default:  add_batch($urandom_range(1, 8));
                endcase
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // all requests offered and taken, then every result in, then a quiet tail
        while (pending_items.size() != 0 || in_bus.valid) @(negedge clk);
        while (shuffled_expect.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d batches from %0d items, longest batch %0d,",
                 batches_closed, items_queued, max_batch);
        $display("%0d items past a full store, checked %0d shuffled results, %0d mismatches",
                 dropped_items, results_checked, err_cnt);
        if (err_cnt == 0)
        begin
            $display("hashed_random_shuffle test passed");
        end
        else
        begin
            $display("hashed_random_shuffle test failed");
        end
        $finish;
    end

endmodule

### files.f
src/hrs_pkg.sv
src/hrs_if.sv
src/hrs_ram.sv
src/hrs_datapath.sv
src/hrs_ctrl.sv
src/hashed_random_shuffle.sv
sim/tb_hashed_random_shuffle.sv
